// ===== hw/rtl/mcpc_pkg.sv =====
// Package: types, constants and tables shared by the coin exchange block.
`default_nettype none
package mcpc_pkg;

	localparam int MAX_PAY_UNITS = 200;
	localparam int NUM_DENOMS    = 6;
	localparam int ADDR_W        = $clog2(MAX_PAY_UNITS + 1);
	localparam int WB_W          = $clog2(MAX_PAY_UNITS + 2);
	localparam int CMP_W         = (ADDR_W > 8) ? ADDR_W : 8;
	localparam int SUM_W         = ((WB_W > 8) ? WB_W : 8) + 1;
	localparam int DEN_W         = 6;
	localparam int OUT_W         = 9;
	localparam int OUT_MAX       = 511;
	localparam logic [WB_W-1:0] WB_INF = '1;

	typedef struct packed {
		logic [7:0] count_5c;
		logic [7:0] count_10c;
		logic [7:0] count_20c;
		logic [7:0] count_50c;
		logic [7:0] count_100c;
		logic [7:0] count_200c;
		logic [7:0] target_units;
	} req_t;

	typedef struct packed {
		logic [OUT_W-1:0] coins_exchanged;
		logic             feasible;
	} rsp_t;

	typedef struct packed {
		logic idle;
		logic done;
	} eng_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PLAN,
		ST_SWEEP,
		ST_DRAIN,
		ST_SEARCH,
		ST_SDRAIN,
		ST_DONE
	} eng_state_t;

	typedef logic [7:0] chg_tab_t [0:MAX_PAY_UNITS];

	// denomination value in 5-cent units
	function automatic logic [DEN_W-1:0] denom_units(input logic [2:0] d);
		logic [DEN_W-1:0] u;
		unique case (d)
			3'd0:    u = DEN_W'(1);
			3'd1:    u = DEN_W'(2);
			3'd2:    u = DEN_W'(4);
			3'd3:    u = DEN_W'(10);
			3'd4:    u = DEN_W'(20);
			3'd5:    u = DEN_W'(40);
			default: u = DEN_W'(1);
		endcase
		return u;
	endfunction

	// most coins of a denomination that can fit in the largest amount
	function automatic logic [ADDR_W-1:0] useful_count(input logic [2:0] d);
		logic [ADDR_W-1:0] n;
		unique case (d)
			3'd0:    n = ADDR_W'(MAX_PAY_UNITS / 1);
			3'd1:    n = ADDR_W'(MAX_PAY_UNITS / 2);
			3'd2:    n = ADDR_W'(MAX_PAY_UNITS / 4);
			3'd3:    n = ADDR_W'(MAX_PAY_UNITS / 10);
			3'd4:    n = ADDR_W'(MAX_PAY_UNITS / 20);
			3'd5:    n = ADDR_W'(MAX_PAY_UNITS / 40);
			default: n = '0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] count_sel(input req_t r, input logic [2:0] d);
		logic [7:0] c;
		unique case (d)
			3'd0:    c = r.count_5c;
			3'd1:    c = r.count_10c;
			3'd2:    c = r.count_20c;
			3'd3:    c = r.count_50c;
			3'd4:    c = r.count_100c;
			3'd5:    c = r.count_200c;
			default: c = '0;
		endcase
		return c;
	endfunction

	// fewest coins for each change amount, unlimited supply
	function automatic chg_tab_t build_change_tab();
		chg_tab_t t;
		int       best;
		int       c;
		int       u;
		t[0] = 8'd0;
		for (int a = 1; a <= MAX_PAY_UNITS; a++) begin
			best = 65535;
			for (int d = 0; d < NUM_DENOMS; d++) begin
				u = int'(denom_units(3'(d)));
				if (a >= u) begin
					c = int'(t[a-u]) + 1;
					if (c < best) best = c;
				end
			end
			t[a] = (best > 255) ? 8'd255 : 8'(best);
		end
		return t;
	endfunction

	localparam chg_tab_t CHANGE_TAB = build_change_tab();

endpackage
`default_nettype wire

// ===== hw/rtl/mcpc_engine.sv =====
// Sequencer, wallet table memory and shared add/compare unit.
`default_nettype none
module mcpc_engine (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  mcpc_pkg::req_t        req,
	input  wire                   take,
	output mcpc_pkg::eng_stat_t   stat,
	output mcpc_pkg::rsp_t        rsp
);
	import mcpc_pkg::*;

	eng_state_t state_q, state_d;

	req_t               req_q;
	logic [2:0]         d_q, d_d;
	logic [ADDR_W-1:0]  rem_q, rem_d;
	logic [ADDR_W:0]    k_q, k_d;
	logic [DEN_W-1:0]   u_q, u_d;
	logic [ADDR_W-1:0]  w_q, w_d;
	logic [ADDR_W-1:0]  c_q, c_d;
	logic [ADDR_W-1:0]  addr_q, addr_d;
	logic               vld_s1, vld_d;
	logic [ADDR_W-1:0]  waddr_s1, waddr_d;
	logic [7:0]         chg_s1, chg_d;
	logic [SUM_W-1:0]   best_q, best_d;
	logic               found_q, found_d;

	logic [WB_W-1:0]    mem [0:MAX_PAY_UNITS];
	logic [WB_W-1:0]    rd0_q, rd1_q;
	logic [ADDR_W-1:0]  raddr0, raddr1, waddr;
	logic [WB_W-1:0]    wdata;
	logic               we;

	logic [CMP_W-1:0]   cnt_x, use_x, tgt_x;
	logic [ADDR_W-1:0]  tgt_a;
	logic [ADDR_W-1:0]  chunk;
	logic [ADDR_W+DEN_W-1:0] prod;

	logic               search_mode;
	logic [SUM_W-1:0]   op_a, op_b, op_ref, sum;
	logic               lt;

	assign cnt_x = CMP_W'(count_sel(req_q, d_q));
	assign use_x = CMP_W'(useful_count(d_q));
	assign tgt_x = CMP_W'(req_q.target_units);
	assign tgt_a = tgt_x[ADDR_W-1:0];
	assign chunk = (k_q > (ADDR_W+1)'(rem_q)) ? rem_q : k_q[ADDR_W-1:0];
	assign prod  = chunk * u_q;

	// shared add/compare: relax step in sweeps, running minimum in search
	assign search_mode = (state_q == ST_SEARCH) || (state_q == ST_SDRAIN);
	always_comb begin
		if (search_mode) begin
			op_a   = SUM_W'(rd0_q);
			op_b   = SUM_W'(chg_s1);
			op_ref = best_q;
		end else begin
			op_a   = SUM_W'(rd1_q);
			op_b   = SUM_W'(c_q);
			op_ref = SUM_W'(rd0_q);
		end
	end
	assign sum = op_a + op_b;
	assign lt  = sum < op_ref;

	always_comb begin
		state_d = state_q;
		d_d     = d_q;
		rem_d   = rem_q;
		k_d     = k_q;
		u_d     = u_q;
		w_d     = w_q;
		c_d     = c_q;
		addr_d  = addr_q;
		vld_d   = 1'b0;
		waddr_d = addr_q;
		chg_d   = CHANGE_TAB[addr_q - tgt_a];
		best_d  = best_q;
		found_d = found_q;
		raddr0  = addr_q;
		raddr1  = addr_q - w_q;
		we      = 1'b0;
		waddr   = waddr_s1;
		wdata   = sum[WB_W-1:0];

		if (vld_s1) begin
			if (search_mode) begin
				if (rd0_q != WB_INF && (!found_q || lt)) begin
					best_d  = sum;
					found_d = 1'b1;
				end
			end else begin
				we = (rd1_q != WB_INF) && lt;
			end
		end

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CLEAR;
					addr_d  = '0;
					found_d = 1'b0;
					best_d  = '0;
					d_d     = '0;
					rem_d   = '0;
				end
			end
			ST_CLEAR: begin
				we     = 1'b1;
				waddr  = addr_q;
				wdata  = (addr_q == '0) ? '0 : WB_INF;
				addr_d = addr_q + 1'b1;
				if (addr_q == ADDR_W'(MAX_PAY_UNITS)) state_d = ST_PLAN;
			end
			ST_PLAN: begin
				if (rem_q == '0) begin
					if (d_q == 3'(NUM_DENOMS)) begin
						if (tgt_x > CMP_W'(MAX_PAY_UNITS)) begin
							state_d = ST_DONE;
						end else begin
							state_d = ST_SEARCH;
							addr_d  = tgt_a;
						end
					end else begin
						rem_d = (cnt_x > use_x) ? use_x[ADDR_W-1:0] : cnt_x[ADDR_W-1:0];
						u_d   = denom_units(d_q);
						k_d   = (ADDR_W+1)'(1);
						d_d   = d_q + 1'b1;
					end
				end else begin
					w_d     = prod[ADDR_W-1:0];
					c_d     = chunk;
					rem_d   = rem_q - chunk;
					k_d     = {k_q[ADDR_W-1:0], 1'b0};
					addr_d  = ADDR_W'(MAX_PAY_UNITS);
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				vld_d  = 1'b1;
				addr_d = addr_q - 1'b1;
				if (addr_q == w_q) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_PLAN;
			end
			ST_SEARCH: begin
				vld_d  = 1'b1;
				addr_d = addr_q + 1'b1;
				if (addr_q == ADDR_W'(MAX_PAY_UNITS)) state_d = ST_SDRAIN;
			end
			ST_SDRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (take) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
			best_q  <= '0;
			d_q     <= '0;
			rem_q   <= '0;
			k_q     <= '0;
			addr_q  <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= vld_d;
			found_q <= found_d;
			best_q  <= best_d;
			d_q     <= d_d;
			rem_q   <= rem_d;
			k_q     <= k_d;
			addr_q  <= addr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) req_q <= req;
		u_q      <= u_d;
		w_q      <= w_d;
		c_q      <= c_d;
		waddr_s1 <= waddr_d;
		chg_s1   <= chg_d;
	end

	// wallet table: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd0_q <= mem[raddr0];
		rd1_q <= mem[raddr1];
	end

	assign stat.idle = (state_q == ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign rsp.feasible = found_q;
	assign rsp.coins_exchanged = !found_q ? '0 :
		(best_q > SUM_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : best_q[OUT_W-1:0];

endmodule
`default_nettype wire

// ===== hw/rtl/min_coins_pay_and_change.sv =====
// Each request first clears the 201-entry wallet table. Each coin count, capped at its
// useful limit, is split into doubling chunks starting at one coin, the last one taking the rest;
// each chunk is one downward sweep of the table, from the top entry down to the chunk's total value,
// through the shared add/compare unit. A search from the target upward follows; a higher target shortens it.
// Throughput: one request at a time; req_ready is low from accept until the result
// moves into the output register. Reset clears all control state; no clearing pass.
`default_nettype none
module min_coins_pay_and_change (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_ready,
	input  mcpc_pkg::req_t    req,
	output logic              rsp_valid,
	input  wire               rsp_ready,
	output mcpc_pkg::rsp_t    rsp
);
	import mcpc_pkg::*;

	eng_stat_t stat;
	rsp_t      eng_rsp;
	rsp_t      rsp_q;
	logic      rsp_valid_q;
	logic      take;

	assign req_ready = stat.idle;
	assign take      = stat.done && (!rsp_valid_q || rsp_ready);

	mcpc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (req_valid && req_ready),
		.req    (req),
		.take   (take),
		.stat   (stat),
		.rsp    (eng_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) rsp_q <= eng_rsp;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// ===== hw/rtl/mcpc_checker.sv =====
// Port-level checks for the coin exchange block, bound to the top level.
`default_nettype none
module mcpc_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               req_valid,
	input wire               req_ready,
	input mcpc_pkg::req_t    req,
	input wire               rsp_valid,
	input wire               rsp_ready,
	input mcpc_pkg::rsp_t    rsp
);
	import mcpc_pkg::*;

	localparam int COIN_CAP = (2 * MAX_PAY_UNITS > OUT_MAX) ? OUT_MAX : 2 * MAX_PAY_UNITS;

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request beat changed while waiting");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	a_infeasible_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.feasible |-> rsp.coins_exchanged == '0)
		else $error("infeasible result with nonzero count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.coins_exchanged <= OUT_W'(COIN_CAP))
		else $error("coin count out of range");

endmodule

bind min_coins_pay_and_change mcpc_checker u_mcpc_checker (.*);
`default_nettype wire
